>>> hdl/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ARM  = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	// Number of slots that the 3-bit slot field can reach.
	localparam int unsigned SLOT_FIELD_SPAN = 8;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  slot;
		logic [31:0] interval;
		logic [7:0]  event_code;
		logic        repeating;
	} req_t;

	typedef struct packed {
		logic [7:0] fired_event;
		logic [2:0] fired_slot;
		logic       last;
	} rsp_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_INC
	} alu_op_t;

endpackage

`default_nettype wire

>>> hdl/soft_timer_pool.sv
`timescale 1ns / 1ps
`default_nettype none

// Pool of software timers driven by a millisecond tick.
// A request carries op, slot, interval, event_code and repeating. An arm
// request loads a slot with deadline = now + period and marks it active; a stop
// request deactivates the slot. Arm, stop and the unused op code finish in the
// cycle they are taken and produce no response.
// A tick request advances the counter, then the sequencer walks the slots in
// ascending order through one shared 32-bit adder: a scan step per slot, plus
// a reload step for each repeating slot that fires to reload its deadline,
// plus a closing flush step. Only slots 0 to 7 exist, even if SLOTS is
// larger, and req_stall is high for the whole walk. Each expired slot gives
// one response; the final one of a tick has last set. A response is held back
// until the next expiry is found or the walk ends.
// The response sits in an output register, so the next request is taken while
// it waits. A stalled response holds the walk at the next expiry found.
// Reset clears the counter and all active flags; slot contents stay undefined.
module soft_timer_pool
	import stp_pkg::*;
#(
	parameter int unsigned SLOTS = 8
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned NSLOT = (SLOTS < SLOT_FIELD_SPAN) ? SLOTS : SLOT_FIELD_SPAN;
	localparam int unsigned IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NSLOT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RELOAD,
		ST_FLUSH
	} state_t;

	state_t      state_q;
	logic [IW-1:0] idx_q;
	logic [31:0] now_q;
	logic [NSLOT-1:0] active_q;
	logic        pend_v_q;
	logic [7:0]  pend_event_q;
	logic [2:0]  pend_slot_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [31:0] deadline_q [NSLOT];
	logic [31:0] period_q   [NSLOT];
	logic [7:0]  event_q    [NSLOT];
	logic        periodic_q [NSLOT];

	alu_op_t     alu_op;
	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic [31:0] alu_sum;
	logic        alu_reached;

	logic          accept;
	logic          slot_ok;
	logic [IW-1:0] req_idx;
	logic          out_free;
	logic          fire;
	logic          push_mid;
	logic          hold_scan;
	logic          push_last;
	logic          idx_end;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid & ~req_stall;
	assign slot_ok   = ({1'b0, req.slot} < 4'(NSLOT));
	assign req_idx   = req.slot[IW-1:0];
	assign out_free  = ~rsp_valid_q | ~rsp_stall;
	assign idx_end   = (idx_q == LAST_IDX);

	assign fire      = (state_q == ST_SCAN) & active_q[idx_q] & alu_reached;
	assign hold_scan = fire & pend_v_q & ~out_free;
	assign push_mid  = fire & pend_v_q & out_free;
	assign push_last = (state_q == ST_FLUSH) & pend_v_q & out_free;

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = now_q;
		alu_b  = req.interval;
		unique case (state_q)
			ST_IDLE: begin
				alu_op = (req.op == OP_TICK) ? ALU_INC : ALU_ADD;
				alu_a  = now_q;
				alu_b  = req.interval;
			end
			ST_SCAN: begin
				alu_op = ALU_SUB;
				alu_a  = now_q;
				alu_b  = deadline_q[idx_q];
			end
			ST_RELOAD: begin
				alu_op = ALU_ADD;
				alu_a  = deadline_q[idx_q];
				alu_b  = period_q[idx_q];
			end
			ST_FLUSH: begin
				alu_op = ALU_ADD;
				alu_a  = now_q;
				alu_b  = req.interval;
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	stp_alu u_alu (
		.op      (alu_op),
		.a       (alu_a),
		.b       (alu_b),
		.sum     (alu_sum),
		.reached (alu_reached)
	);

	// Slot contents: written by arm requests and by deadline reloads.
	always_ff @(posedge clk) begin
		if (accept && req.op == OP_ARM && slot_ok) begin
			deadline_q[req_idx] <= alu_sum;
			period_q[req_idx]   <= req.interval;
			event_q[req_idx]    <= req.event_code;
			periodic_q[req_idx] <= req.repeating;
		end else if (state_q == ST_RELOAD) begin
			deadline_q[idx_q] <= alu_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			now_q        <= '0;
			active_q     <= '0;
			pend_v_q     <= 1'b0;
			pend_event_q <= '0;
			pend_slot_q  <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (push_mid || push_last) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.fired_event <= pend_event_q;
				rsp_q.fired_slot  <= pend_slot_q;
				rsp_q.last        <= push_last;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.op)
							OP_TICK: begin
								now_q   <= alu_sum;
								idx_q   <= '0;
								state_q <= ST_SCAN;
							end
							OP_ARM: begin
								if (slot_ok) begin
									active_q[req_idx] <= 1'b1;
								end
							end
							OP_STOP: begin
								if (slot_ok) begin
									active_q[req_idx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (fire) begin
						if (!hold_scan) begin
							pend_v_q     <= 1'b1;
							pend_event_q <= event_q[idx_q];
							pend_slot_q  <= 3'(idx_q);
							if (periodic_q[idx_q]) begin
								state_q <= ST_RELOAD;
							end else begin
								active_q[idx_q] <= 1'b0;
								if (idx_end) begin
									state_q <= ST_FLUSH;
								end else begin
									idx_q <= idx_q + 1'b1;
								end
							end
						end
					end else if (idx_end) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RELOAD: begin
					if (idx_end) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// No expiry may be left pending once the walk has returned to idle.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending expiry left behind at idle");

	// A response is never loaded over one that the receiver is still holding.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !(push_mid || push_last))
		else $error("response overwritten while stalled");

	// A tick always starts its walk at the lowest slot.
	a_tick_starts_low: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.op == OP_TICK) |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("tick did not start walk at the first slot");

endmodule

`default_nettype wire

>>> hdl/stp_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_alu
	import stp_pkg::*;
(
	input  alu_op_t     op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum,
	output logic        reached
);

	logic [31:0] b_eff;
	logic        carry_in;

	always_comb begin
		b_eff    = b;
		carry_in = 1'b0;
		unique case (op)
			ALU_ADD: begin
				b_eff    = b;
				carry_in = 1'b0;
			end
			ALU_SUB: begin
				b_eff    = ~b;
				carry_in = 1'b1;
			end
			ALU_INC: begin
				b_eff    = '0;
				carry_in = 1'b1;
			end
			default: begin
				b_eff    = b;
				carry_in = 1'b0;
			end
		endcase
	end

	assign sum = a + b_eff + {31'd0, carry_in};

	// After a subtract of the deadline from the counter, a clear sign bit means
	// the deadline has been reached, even across a counter wrap.
	assign reached = ~sum[31];

endmodule

`default_nettype wire

>>> tb/sv/tb_soft_timer_pool.sv
`timescale 1ns / 1ps

module tb_soft_timer_pool;
	import stp_pkg::*;

	localparam int NSLOT = 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 355;
	localparam int CYCLE_LIMIT = 600000;

	class timer_scoreboard;
		logic [31:0] now_ms;
		logic [31:0] due_ms [NSLOT];
		logic [31:0] reload_ms [NSLOT];
		logic [7:0]  code [NSLOT];
		bit          reloads [NSLOT];
		bit          armed [NSLOT];
		rsp_t        pending_fires [$];
		int errors;
		int ticks;
		int arms;
		int stops;
		int ignored;
		int fired;

		function new();
			now_ms = '0;
			foreach (armed[k]) armed[k] = 1'b0;
			errors = 0;
			ticks = 0;
			arms = 0;
			stops = 0;
			ignored = 0;
			fired = 0;
		endfunction

		// Apply one accepted request and queue the expiries that it causes.
		function void note_request(req_t r);
			rsp_t tick_fires [$];
			rsp_t one;
			logic [31:0] diff;
			case (r.op)
				OP_ARM: begin
					arms++;
					if (r.slot < NSLOT) begin
						due_ms[r.slot] = now_ms + r.interval;
						reload_ms[r.slot] = r.interval;
						code[r.slot] = r.event_code;
						reloads[r.slot] = r.repeating;
						armed[r.slot] = 1'b1;
					end
				end
				OP_STOP: begin
					stops++;
					if (r.slot < NSLOT)
						armed[r.slot] = 1'b0;
				end
				OP_TICK: begin
					ticks++;
					now_ms = now_ms + 32'd1;
					for (int k = 0; k < NSLOT; k++) begin
						if (armed[k]) begin
							diff = now_ms - due_ms[k];
							// The wrap-safe difference is non-negative once the deadline is reached.
							if (!diff[31]) begin
								one.fired_event = code[k];
								one.fired_slot = k[2:0];
								one.last = 1'b0;
								tick_fires.push_back(one);
								if (reloads[k])
									due_ms[k] = due_ms[k] + reload_ms[k];
								else
									armed[k] = 1'b0;
							end
						end
					end
					if (tick_fires.size() > 0)
						tick_fires[tick_fires.size() - 1].last = 1'b1;
					foreach (tick_fires[i]) pending_fires.push_back(tick_fires[i]);
				end
				default: ignored++;
			endcase
		endfunction

		function void check_fire(rsp_t got);
			rsp_t want;
			if (pending_fires.size() == 0) begin
				$error("response with no expiry pending: fired_event %0d fired_slot %0d last %0d",
					got.fired_event, got.fired_slot, got.last);
				errors++;
				return;
			end
			want = pending_fires.pop_front();
			fired++;
			if (got.fired_event !== want.fired_event) begin
				$error("fired_event: expected %0d, actual %0d", want.fired_event, got.fired_event);
				errors++;
			end
			if (got.fired_slot !== want.fired_slot) begin
				$error("fired_slot: expected %0d, actual %0d", want.fired_slot, got.fired_slot);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_fires.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	timer_scoreboard sb = new();
	int cycle_count = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	soft_timer_pool u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The receiver switches between free flow, light, heavy and periodic stalling.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 150);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= stall_left[3];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_fire(rsp);
		end
	end

	function automatic req_t make_req(logic [1:0] op, logic [2:0] slot, logic [31:0] period,
		logic [7:0] ev, logic rep);
		req_t r;
		r.op = op;
		r.slot = slot;
		r.interval = period;
		r.event_code = ev;
		r.repeating = rep;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int sel;
		int pick;
		sel = $urandom_range(0, 99);
		r.slot = 3'($urandom_range(0, 7));
		r.event_code = 8'($urandom_range(0, 255));
		r.repeating = 1'($urandom_range(0, 1));
		r.interval = $urandom();
		if (sel < 45) begin
			r.op = OP_TICK;
		end else if (sel < 80) begin
			r.op = OP_ARM;
			pick = $urandom_range(0, 19);
			// Mostly short periods so that slots keep expiring within the run.
			if (pick < 15)
				r.interval = $urandom_range(0, 12);
			else if (pick < 17)
				r.interval = 32'hFFFF_FFF0 | $urandom_range(0, 15);
		end else if (sel < 94) begin
			r.op = OP_STOP;
		end else begin
			r.op = OP_UNUSED;
		end
		return r;
	endfunction

	task automatic issue(input req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic drain_pool();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (2 * NSLOT + 8) @(posedge clk);
	endtask

	initial begin
		int counted;
		bit drained;
		req_t r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		counted = 0;
		drained = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty tick, ignored op code, zero and wrapping periods, far deadline.
		issue(make_req(OP_TICK, 3'd0, 32'd0, 8'd0, 1'b0));
		issue(make_req(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 8'hFF, 1'b1));
		issue(make_req(OP_ARM, 3'd0, 32'd0, 8'h00, 1'b0));
		issue(make_req(OP_ARM, 3'd7, 32'd0, 8'hFF, 1'b1));
		issue(make_req(OP_ARM, 3'd3, 32'd2, 8'hA5, 1'b1));
		issue(make_req(OP_ARM, 3'd5, 32'hFFFF_FFFF, 8'h5A, 1'b0));
		issue(make_req(OP_ARM, 3'd6, 32'h8000_0000, 8'h3C, 1'b1));
		issue(make_req(OP_TICK, 3'd7, 32'hFFFF_FFFF, 8'hFF, 1'b1));
		issue(make_req(OP_TICK, 3'd0, 32'd0, 8'd0, 1'b0));
		// Fill every slot with a period of zero so that one tick fires all of them.
		for (int k = 0; k < NSLOT; k++)
			issue(make_req(OP_ARM, k[2:0], 32'd0, 8'h10 + k[7:0], 1'b1));
		issue(make_req(OP_TICK, 3'd0, 32'd0, 8'd0, 1'b0));
		issue(make_req(OP_TICK, 3'd0, 32'd0, 8'd0, 1'b0));
		issue(make_req(OP_STOP, 3'd7, 32'd0, 8'd0, 1'b0));
		issue(make_req(OP_STOP, 3'd6, 32'hFFFF_FFFF, 8'hFF, 1'b1));
		issue(make_req(OP_ARM, 3'd1, 32'd1, 8'h77, 1'b0));
		issue(make_req(OP_TICK, 3'd0, 32'd0, 8'd0, 1'b0));
		issue(make_req(OP_STOP, 3'd1, 32'd0, 8'd0, 1'b0));
		issue(make_req(OP_TICK, 3'd0, 32'd0, 8'd0, 1'b0));

		while (counted < RANDOM_REQUESTS) begin
			r = random_request();
			issue(r);
			counted++;
			if (!drained && counted == RANDOM_REQUESTS / 2) begin
				drain_pool();
				drained = 1'b1;
			end
		end

		drain_pool();
		$display("Ran %0d ticks, %0d arms, %0d stops and %0d ignored requests.",
			sb.ticks, sb.arms, sb.stops, sb.ignored);
		$display("Checked %0d timer expiries against the prediction.", sb.fired);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> soft_timer_pool.f
hdl/stp_pkg.sv
hdl/stp_alu.sv
hdl/soft_timer_pool.sv
tb/sv/tb_soft_timer_pool.sv
